// ===== rtl/core/cdq_pkg.sv =====
// Shared operation codes, status codes and controller command type for the deque.
package cdq_pkg;

    localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
    localparam logic [1:0] OP_POP_FRONT  = 2'd1;
    localparam logic [1:0] OP_PUSH_FRONT = 2'd2;
    localparam logic [1:0] OP_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [5:0] CAP_RESET = 6'd32;

    typedef struct packed {
        logic load;
        logic exec;
        logic respond;
    } t_cdq_cmd;

endpackage

// ===== rtl/core/circular_deque.sv =====
// Top level of the circular double-ended queue: controller and datapath.
// Each transaction is accepted, then has an execute step that writes the slot on a
// push, reads the addressed slot and moves the indices and count, and then a step
// in which the result is shown with o_valid high for exactly one cycle.
// o_busy stays high for the execute and result cycles, so a new transaction can
// start in the cycle after the result. The receiver cannot stall the result.
// The capacity register resets to 32 and takes effect from the next transaction.
// The user must write it only while o_busy is low; the block does not check.
// Zero acts as one, values above DEPTH as DEPTH; unwritten slots read undefined.
module circular_deque #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_push_value,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    output logic               o_valid,
    output logic signed [31:0] o_popped_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_entries
);
    import cdq_pkg::*;

    t_cdq_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entries      (o_entries)
    );

    assign o_valid = cmd.respond;

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Controller state machine sequencing load, execute and response of one transaction.
module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output cdq_pkg::t_cdq_cmd o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.load    = i_start && (r_state == S_IDLE);
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.respond = (r_state == S_RESP);

endmodule

// ===== rtl/core/cdq_dpath.sv =====
// Datapath: slot store, front and rear indices, element count and capacity register.
module cdq_dpath #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdq_pkg::t_cdq_cmd  i_cmd,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_push_value,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    output logic signed [31:0] o_popped_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_entries
);
    import cdq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = ((IDX_W > 6) ? IDX_W : 6) + 1;
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    logic [31:0]      r_mem [DEPTH];
    logic [31:0]      r_rd;
    logic [1:0]       r_op;
    logic [31:0]      r_val;
    logic [5:0]       r_capacity;
    logic [IDX_W-1:0] r_front;
    logic [IDX_W-1:0] r_rear;
    logic [5:0]       r_count;
    logic [1:0]       r_status;
    logic             r_pop_ok;

    logic [5:0]       cap;
    logic             is_push;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] n_front;
    logic [IDX_W-1:0] n_rear;
    logic [5:0]       n_count;
    logic [1:0]       n_status;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                  input logic [5:0] c);
        logic [WW-1:0] nx;
        nx = WW'(idx) + WW'(1);
        return (nx >= WW'(c)) ? '0 : nx[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                   input logic [5:0] c);
        logic [WW-1:0] cm1;
        cm1 = WW'(c) - WW'(1);
        return (idx == '0) ? cm1[IDX_W-1:0] : idx - IDX_W'(1);
    endfunction

    always_comb begin
        if (r_capacity == 6'd0) begin
            cap = 6'd1;
        end else if (WW'(r_capacity) > DEPTH_W) begin
            cap = DEPTH_W[5:0];
        end else begin
            cap = r_capacity;
        end
    end

    assign is_push = (r_op == OP_PUSH_REAR) || (r_op == OP_PUSH_FRONT);
    assign full    = (r_count >= cap);
    assign empty   = (r_count == 6'd0);
    assign rd_addr = (r_op == OP_POP_FRONT) ? r_front : r_rear;

    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = '0;
        if (is_push) begin
            if (full) begin
                n_status = ST_OVERFLOW;
            end else begin
                wr_en   = 1'b1;
                n_count = r_count + 6'd1;
                if (empty) begin
                    n_front = '0;
                    n_rear  = '0;
                    wr_addr = '0;
                end else if (r_op == OP_PUSH_REAR) begin
                    n_rear  = step_fwd(r_rear, cap);
                    wr_addr = n_rear;
                end else begin
                    n_front = step_back(r_front, cap);
                    wr_addr = n_front;
                end
            end
        end else begin
            if (empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                n_count = r_count - 6'd1;
                if (r_op == OP_POP_FRONT) begin
                    n_front = step_fwd(r_front, cap);
                end else begin
                    n_rear = step_back(r_rear, cap);
                end
                if (n_count == 6'd0) begin
                    n_front = '0;
                    n_rear  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_val;
        end
        if (i_cmd.exec) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_front    <= '0;
            r_rear     <= '0;
            r_count    <= '0;
            r_pop_ok   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_front  <= n_front;
                r_rear   <= n_rear;
                r_count  <= n_count;
                r_pop_ok <= !is_push && !empty;
            end
        end
    end

    assign o_popped_value = r_pop_ok ? r_rd : '0;
    assign o_status       = r_status;
    assign o_entries      = r_count;

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 6'd0) |-> (r_front == '0 && r_rear == '0))
        else $error("empty deque with indices away from slot zero");

    a_overflow_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_push && full)
        |=> ($stable(r_count) && $stable(r_front) && $stable(r_rear)))
        else $error("overflowed push changed the deque");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_push && !full) |=> (r_count == $past(r_count) + 6'd1))
        else $error("push did not add one element");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.respond && r_status == ST_UNDERFLOW) |-> (r_count == 6'd0 && !r_pop_ok))
        else $error("underflow reported with elements held");

endmodule

// ===== test/tb_circular_deque.sv =====
// Self-checking testbench for the circular deque: directed corner cases, then random phases.
module tb_circular_deque;
    import cdq_pkg::*;

    localparam int DEPTH = 32;

    class deque_scoreboard;
        typedef struct {
            logic [1:0]  op;
            logic [31:0] popped;
            logic [1:0]  status;
            logic [5:0]  entries;
        } t_deque_result;

        logic [31:0]   slot_mem [DEPTH];
        int            head_idx;
        int            tail_idx;
        int            held;
        logic [5:0]    cap_reg;
        t_deque_result expected_q [$];
        int            mismatches;

        function new();
            foreach (slot_mem[i]) slot_mem[i] = '0;
            head_idx   = 0;
            tail_idx   = 0;
            held       = 0;
            cap_reg    = CAP_RESET;
            mismatches = 0;
        endfunction

        function void set_capacity(logic [5:0] value);
            cap_reg = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_operation(logic [1:0] op, logic [31:0] value);
            t_deque_result r;
            int            usable;
            usable = int'(cap_reg);
            if (usable == 0) usable = 1;
            if (usable > DEPTH) usable = DEPTH;
            r.op     = op;
            r.popped = '0;
            r.status = ST_DONE;
            if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) begin
                if (held >= usable) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    if (held == 0) begin
                        head_idx    = 0;
                        tail_idx    = 0;
                        slot_mem[0] = value;
                    end else if (op == OP_PUSH_REAR) begin
                        tail_idx = (tail_idx + 1 >= usable) ? 0 : tail_idx + 1;
                        slot_mem[tail_idx] = value;
                    end else begin
                        head_idx = (head_idx == 0) ? usable - 1 : head_idx - 1;
                        slot_mem[head_idx] = value;
                    end
                    held++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    if (op == OP_POP_FRONT) begin
                        r.popped = slot_mem[head_idx];
                        head_idx = (head_idx + 1 >= usable) ? 0 : head_idx + 1;
                    end else begin
                        r.popped = slot_mem[tail_idx];
                        tail_idx = (tail_idx == 0) ? usable - 1 : tail_idx - 1;
                    end
                    held--;
                    if (held == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end
                end
            end
            r.entries = 6'(held);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [31:0] popped, logic [1:0] status, logic [5:0] entries);
            t_deque_result r;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result: popped %h status %0d entries %0d",
                             popped, status, entries);
                return;
            end
            r = expected_q.pop_front();
            if (popped !== r.popped || status !== r.status || entries !== r.entries) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: op %0d want popped %h status %0d entries %0d, got %h %0d %0d",
                             r.op, r.popped, r.status, r.entries, popped, status, entries);
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_start      = 1'b0;
    logic [1:0]         i_operation  = OP_PUSH_REAR;
    logic signed [31:0] i_push_value = '0;
    logic               i_cfg_we     = 1'b0;
    logic [5:0]         i_cfg_wdata  = '0;
    logic               o_busy;
    logic               o_valid;
    logic signed [31:0] o_popped_value;
    logic [1:0]         o_status;
    logic [5:0]         o_entries;

    deque_scoreboard sb;
    int              idle_pct = 0;

    circular_deque #(.DEPTH(DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entries      (o_entries)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_popped_value, o_status, o_entries);
            if (i_cfg_we)
                sb.set_capacity(i_cfg_wdata);
            if (i_start && !o_busy)
                sb.note_operation(i_operation, i_push_value);
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] value);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_operation  <= op;
        i_push_value <= value;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [5:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int n, logic [5:0] cap, int idle, int push_pct, bit hold_off);
        logic [1:0] op;
        write_capacity(cap);
        idle_pct = idle;
        for (int i = 0; i < n; i++) begin
            if (hold_off && i == n / 2)
                drain();
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            send_item(op, pick_value());
        end
    endtask

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 0;
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_POP_REAR, 32'h0);
        send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(OP_POP_REAR, 32'h0);
        send_item(OP_PUSH_REAR, 32'h8000_0000);
        send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_POP_FRONT, 32'h0);
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_PUSH_REAR, pick_value());
        send_item(OP_PUSH_REAR, 32'h1234_5678);
        send_item(OP_PUSH_FRONT, 32'h0000_0001);
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(OP_POP_REAR, 32'h0);
        send_item(OP_PUSH_REAR, 32'h0);

        run_phase(88, 6'd5, 87, 60, 1'b0);
        run_phase(88, 6'd32, 0, 50, 1'b1);
        run_phase(88, 6'd0, 13, 50, 1'b0);
        run_phase(88, 6'd63, 0, 70, 1'b0);
        run_phase(88, 6'd1, 87, 50, 1'b0);
        run_phase(88, 6'($urandom_range(2, 31)), 13, 40, 1'b1);
        run_phase(88, 6'd45, 0, 55, 1'b0);
        run_phase(88, 6'd3, 13, 50, 1'b0);

        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
